// ----- design/spfl_pkg.sv -----
// Shared types and constants for the slot pool allocator.
package spfl_pkg;

  localparam int MODE_W       = 2;
  localparam int SLOT_ID_W    = 16;
  localparam int SLOT_INDEX_W = 10;
  localparam int STATUS_W     = 2;
  localparam int LIVE_TOTAL_W = 11;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

endpackage

// ----- design/spfl_if.sv -----
// Request and response channel interfaces for the slot pool allocator.
interface spfl_req_if;
  logic                               valid;
  logic                               ready;
  logic [spfl_pkg::MODE_W-1:0]        mode;
  logic [spfl_pkg::SLOT_ID_W-1:0]     slot_id;

  modport source (output valid, output mode, output slot_id, input ready);
  modport sink   (input valid, input mode, input slot_id, output ready);
endinterface

interface spfl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [spfl_pkg::SLOT_INDEX_W-1:0]  slot_index;
  logic [spfl_pkg::STATUS_W-1:0]      status;
  logic                               is_live;
  logic [spfl_pkg::LIVE_TOTAL_W-1:0]  live_total;

  modport source (output valid, output slot_index, output status, output is_live,
                  output live_total, input ready);
  modport sink   (input valid, input slot_index, input status, input is_live,
                  input live_total, output ready);
endinterface

// ----- design/spfl_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module spfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/slot_pool_free_list_allocator.sv -----
// Top level of the slot pool allocator: control, counters and the two state memories.
//
//   channel   direction  handshake              payload
//   in_req    sink       in_req.valid/ready     mode, slot_id
//   out_rsp   source     out_rsp.valid/ready    slot_index, status, is_live, live_total
//
// Each request has an accept step, reading the free stack and alive-bit memory, then an
// execute step: it updates counters, writes the stack on a good free and the alive bit
// on a grant or good free, and loads the response register. A new request is taken the
// cycle after the execute step. Reset is synchronous; no clearing pass, since slots at
// or above the high-water mark read as dead; a stalled response holds the execute step.
module slot_pool_free_list_allocator #(
  parameter int SLOTS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  spfl_req_if.sink   in_req,
  spfl_rsp_if.source out_rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > spfl_pkg::SLOT_ID_W) ? CNT_W : spfl_pkg::SLOT_ID_W;

  spfl_pkg::fsm_state_t state_r, state_nxt;

  logic [spfl_pkg::MODE_W-1:0]    mode_r;
  logic [spfl_pkg::SLOT_ID_W-1:0] sid_r;
  logic [CNT_W-1:0]               free_depth_r, free_depth_nxt;
  logic [CNT_W-1:0]               high_water_r, high_water_nxt;
  logic [CNT_W-1:0]               live_count_r, live_count_nxt;

  logic                               out_valid_r;
  logic [spfl_pkg::SLOT_INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [spfl_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic                               out_live_r, out_live_nxt;

  logic             accept;
  logic             exec_fire;
  logic             out_free;
  logic             in_ready;

  logic [CNT_W-1:0] depth_dec;
  logic [IDX_W-1:0] sid_idx;
  logic [IDX_W-1:0] stack_rdata;
  logic             alive_rdata;
  logic             in_range;
  logic             slot_alive;
  logic             got_slot;
  logic [IDX_W-1:0] grant_idx;
  logic             free_ok;

  logic             stack_we;
  logic             alive_we;
  logic [IDX_W-1:0] alive_waddr;
  logic             alive_wdata;

  assign depth_dec = free_depth_r - CNT_W'(1);
  assign sid_idx   = IDX_W'(in_req.slot_id);
  assign accept    = in_req.valid && in_ready;
  assign out_free  = !out_valid_r || out_rsp.ready;

  spfl_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (free_depth_r[IDX_W-1:0]),
    .wdata (sid_r[IDX_W-1:0]),
    .re    (accept),
    .raddr (depth_dec[IDX_W-1:0]),
    .rdata (stack_rdata)
  );

  spfl_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_alive (
    .clk   (clk),
    .we    (alive_we),
    .waddr (alive_waddr),
    .wdata (alive_wdata),
    .re    (accept),
    .raddr (sid_idx),
    .rdata (alive_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spfl_pkg::FSM_IDLE: begin
        if (accept) begin
          state_nxt = spfl_pkg::FSM_EXEC;
        end
      end
      spfl_pkg::FSM_EXEC: begin
        if (out_free) begin
          state_nxt = spfl_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = spfl_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      spfl_pkg::FSM_IDLE: in_ready  = 1'b1;
      spfl_pkg::FSM_EXEC: exec_fire = out_free;
      default: begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign in_range   = CMP_W'(sid_r) < CMP_W'(high_water_r);
  assign slot_alive = in_range && alive_rdata;

  always_comb begin
    free_depth_nxt = free_depth_r;
    high_water_nxt = high_water_r;
    live_count_nxt = live_count_r;
    got_slot       = 1'b0;
    free_ok        = 1'b0;
    grant_idx      = '0;
    out_index_nxt  = sid_r[spfl_pkg::SLOT_INDEX_W-1:0];
    out_status_nxt = spfl_pkg::ST_OK;
    out_live_nxt   = 1'b0;
    case (mode_r)
      spfl_pkg::MODE_ALLOC: begin
        if (free_depth_r != '0) begin
          free_depth_nxt = depth_dec;
          grant_idx      = stack_rdata;
          got_slot       = 1'b1;
        end else if (high_water_r < CNT_W'(SLOTS)) begin
          high_water_nxt = high_water_r + CNT_W'(1);
          grant_idx      = high_water_r[IDX_W-1:0];
          got_slot       = 1'b1;
        end
        if (got_slot) begin
          live_count_nxt = live_count_r + CNT_W'(1);
          out_index_nxt  = spfl_pkg::SLOT_INDEX_W'(grant_idx);
          out_live_nxt   = 1'b1;
        end else begin
          out_index_nxt  = '0;
          out_status_nxt = spfl_pkg::ST_FULL;
        end
      end
      spfl_pkg::MODE_FREE: begin
        if (slot_alive && (free_depth_r < CNT_W'(SLOTS))) begin
          free_ok        = 1'b1;
          free_depth_nxt = free_depth_r + CNT_W'(1);
          if (live_count_r != '0) begin
            live_count_nxt = live_count_r - CNT_W'(1);
          end
        end else begin
          out_status_nxt = spfl_pkg::ST_BAD_FREE;
        end
      end
      default: out_live_nxt = slot_alive;
    endcase
  end

  assign stack_we    = exec_fire && free_ok;
  assign alive_we    = exec_fire && (got_slot || free_ok);
  assign alive_waddr = got_slot ? grant_idx : sid_r[IDX_W-1:0];
  assign alive_wdata = got_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spfl_pkg::FSM_IDLE;
      free_depth_r <= '0;
      high_water_r <= '0;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        free_depth_r <= free_depth_nxt;
        high_water_r <= high_water_nxt;
        live_count_r <= live_count_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_req.mode;
      sid_r  <= in_req.slot_id;
    end
    if (exec_fire) begin
      out_index_r  <= out_index_nxt;
      out_status_r <= out_status_nxt;
      out_live_r   <= out_live_nxt;
    end
  end

  assign in_req.ready       = in_ready;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.slot_index = out_index_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.is_live    = out_live_r;
  assign out_rsp.live_total = spfl_pkg::LIVE_TOTAL_W'(live_count_r);

  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_count_r} + {1'b0, free_depth_r}) == {1'b0, high_water_r})
    else $error("live count plus free depth differs from high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, high_water_r} <= (CNT_W + 1)'(SLOTS))
    else $error("high-water mark beyond pool size");

  a_exec_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("execute step did not present a response");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second request taken before the first was executed");

endmodule
